/* hdl/rectangle_difference_top_defines.svh */
// assertion macros shared by the rectangle difference checker
// no dependencies; clk and rst_n must be visible where the macros are used
`ifndef RECTANGLE_DIFFERENCE_TOP_DEFINES_SVH
`define RECTANGLE_DIFFERENCE_TOP_DEFINES_SVH

// property checked out of reset
`define RD_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rectangle difference check failed");

// property that looks at reset itself
`define RD_CHECK_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rectangle difference reset check failed");

`endif

/* hdl/rd_pkg.sv */
// shared types and codes for the rectangle difference block
// no dependencies
`default_nettype none

package rd_pkg;

  // what the back end does with a queued item
  localparam logic [1:0] KIND_WHOLE  = 2'd0;  // no overlap, pass A through
  localparam logic [1:0] KIND_COVER  = 2'd1;  // A fully covered
  localparam logic [1:0] KIND_PIECES = 2'd2;  // one to four remainder pieces

  // piece slots, emitted lowest first
  localparam int PC_TOP    = 0;
  localparam int PC_LEFT   = 1;
  localparam int PC_RIGHT  = 2;
  localparam int PC_BOTTOM = 3;
  localparam int NUM_PC    = 4;

  // coordinates carried per queued item: A, then the clipped area
  localparam int NUM_CRD = 8;
  localparam int CI_L  = 0;
  localparam int CI_T  = 1;
  localparam int CI_R  = 2;
  localparam int CI_B  = 3;
  localparam int CI_X0 = 4;
  localparam int CI_Y0 = 5;
  localparam int CI_X1 = 6;
  localparam int CI_Y1 = 7;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NUM_PC-1:0] mask;
  } rd_ctl_t;

endpackage

`default_nettype wire

/* hdl/rd_front.sv */
// front end: clips B to A and classifies the clipped area into piece slots
// depends on rd_pkg
`default_nettype none

module rd_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic signed [COORD_BITS-1:0]              a_left,
  input  wire logic signed [COORD_BITS-1:0]              a_top,
  input  wire logic signed [COORD_BITS-1:0]              a_right,
  input  wire logic signed [COORD_BITS-1:0]              a_bottom,
  input  wire logic signed [COORD_BITS-1:0]              b_left,
  input  wire logic signed [COORD_BITS-1:0]              b_top,
  input  wire logic signed [COORD_BITS-1:0]              b_right,
  input  wire logic signed [COORD_BITS-1:0]              b_bottom,
  output rd_pkg::rd_ctl_t                                ctl,
  output logic [rd_pkg::NUM_CRD*COORD_BITS-1:0]          crd
);

  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic overlap, lx, rx, ty, by;
  logic [rd_pkg::NUM_PC-1:0] mask;

  always_comb begin
    x0 = (b_left   > a_left)   ? b_left   : a_left;
    y0 = (b_top    > a_top)    ? b_top    : a_top;
    x1 = (b_right  < a_right)  ? b_right  : a_right;
    y1 = (b_bottom < a_bottom) ? b_bottom : a_bottom;
    overlap = (x0 < x1) && (y0 < y1);
    lx = (x0 == a_left);
    rx = (x1 == a_right);
    ty = (y0 == a_top);
    by = (y1 == a_bottom);

    // side pieces span y0..y1; y1 equals the bottom of A when the bottom is touched
    mask = '0;
    mask[rd_pkg::PC_TOP]    = !ty;
    mask[rd_pkg::PC_LEFT]   = !lx;
    mask[rd_pkg::PC_RIGHT]  = !rx;
    mask[rd_pkg::PC_BOTTOM] = !by;

    if (!overlap) begin
      ctl.kind = rd_pkg::KIND_WHOLE;
      ctl.mask = rd_pkg::NUM_PC'(1);
    end else if (mask == '0) begin
      ctl.kind = rd_pkg::KIND_COVER;
      ctl.mask = rd_pkg::NUM_PC'(1);
    end else begin
      ctl.kind = rd_pkg::KIND_PIECES;
      ctl.mask = mask;
    end

    crd = {y1, x1, y0, x0, a_bottom, a_right, a_top, a_left};
  end

endmodule

`default_nettype wire

/* hdl/rd_queue.sv */
// two-entry first-word-fall-through queue between front and back end
// no dependencies
`default_nettype none

module rd_queue #(
  parameter int WIDTH = 134
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int DEPTH = 2;
  localparam int AW    = 1;

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = store_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? wp_r + AW'(1) : wp_r;
    rp_nxt  = rd_en ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* hdl/rd_back.sv */
// back end: walks the piece slots of one item and emits one result a cycle while out_pop takes each result
// depends on rd_pkg
`default_nettype none

module rd_back #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     q_empty,
  input  wire rd_pkg::rd_ctl_t                          q_ctl,
  input  wire logic [rd_pkg::NUM_CRD*COORD_BITS-1:0]    q_crd,
  output logic                                          q_pop,
  output logic                                          out_empty,
  input  wire logic                                     out_pop,
  output logic [COORD_BITS-1:0]                         piece_left,
  output logic [COORD_BITS-1:0]                         piece_top,
  output logic [COORD_BITS-1:0]                         piece_right,
  output logic [COORD_BITS-1:0]                         piece_bottom,
  output logic                                          piece_valid,
  output logic                                          last_piece
);

  localparam int CB = COORD_BITS;

  // working item
  logic                                  busy_r, busy_nxt;
  logic [1:0]                            kind_r, kind_nxt;
  logic [rd_pkg::NUM_PC-1:0]             rem_r, rem_nxt;
  logic [rd_pkg::NUM_CRD*CB-1:0]         crd_r, crd_nxt;

  // output register
  logic          ovld_r, ovld_nxt;
  logic [CB-1:0] pl_r, pl_nxt, pt_r, pt_nxt, pr_r, pr_nxt, pb_r, pb_nxt;
  logic          pv_r, pv_nxt, lp_r, lp_nxt;

  logic [rd_pkg::NUM_PC-1:0] sel, rem_after;
  logic [CB-1:0] c_l, c_t, c_r, c_b, c_x0, c_y0, c_x1, c_y1;
  logic adv, issue, done, load;

  assign c_l  = crd_r[rd_pkg::CI_L*CB  +: CB];
  assign c_t  = crd_r[rd_pkg::CI_T*CB  +: CB];
  assign c_r  = crd_r[rd_pkg::CI_R*CB  +: CB];
  assign c_b  = crd_r[rd_pkg::CI_B*CB  +: CB];
  assign c_x0 = crd_r[rd_pkg::CI_X0*CB +: CB];
  assign c_y0 = crd_r[rd_pkg::CI_Y0*CB +: CB];
  assign c_x1 = crd_r[rd_pkg::CI_X1*CB +: CB];
  assign c_y1 = crd_r[rd_pkg::CI_Y1*CB +: CB];

  always_comb begin
    sel       = rem_r & (~rem_r + rd_pkg::NUM_PC'(1));
    rem_after = rem_r & (rem_r - rd_pkg::NUM_PC'(1));
    adv       = !ovld_r || out_pop;
    issue     = busy_r && adv;
    done      = issue && (rem_after == '0);
    load      = (!busy_r || done) && !q_empty;

    busy_nxt = busy_r;
    kind_nxt = kind_r;
    rem_nxt  = rem_r;
    crd_nxt  = crd_r;
    if (load) begin
      busy_nxt = 1'b1;
      kind_nxt = q_ctl.kind;
      rem_nxt  = q_ctl.mask;
      crd_nxt  = q_crd;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      rem_nxt = rem_after;
    end

    ovld_nxt = ovld_r;
    pl_nxt = pl_r;
    pt_nxt = pt_r;
    pr_nxt = pr_r;
    pb_nxt = pb_r;
    pv_nxt = pv_r;
    lp_nxt = lp_r;
    if (issue) begin
      ovld_nxt = 1'b1;
      lp_nxt   = (rem_after == '0);
      pv_nxt   = 1'b1;
      case (kind_r)
        rd_pkg::KIND_WHOLE: begin
          pl_nxt = c_l;  pt_nxt = c_t;  pr_nxt = c_r;  pb_nxt = c_b;
        end
        rd_pkg::KIND_COVER: begin
          pl_nxt = '0;  pt_nxt = '0;  pr_nxt = '0;  pb_nxt = '0;
          pv_nxt = 1'b0;
        end
        default: begin
          // slot select is one-hot
          pl_nxt = c_l;  pt_nxt = c_y1;  pr_nxt = c_r;  pb_nxt = c_b;
          if (sel[rd_pkg::PC_TOP]) begin
            pt_nxt = c_t;  pb_nxt = c_y0;
          end else if (sel[rd_pkg::PC_LEFT]) begin
            pt_nxt = c_y0;  pr_nxt = c_x0;  pb_nxt = c_y1;
          end else if (sel[rd_pkg::PC_RIGHT]) begin
            pl_nxt = c_x1;  pt_nxt = c_y0;  pb_nxt = c_y1;
          end
        end
      endcase
    end else if (adv) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    rem_r  <= rem_nxt;
    crd_r  <= crd_nxt;
    pl_r   <= pl_nxt;
    pt_r   <= pt_nxt;
    pr_r   <= pr_nxt;
    pb_r   <= pb_nxt;
    pv_r   <= pv_nxt;
    lp_r   <= lp_nxt;
  end

  assign q_pop        = load;
  assign out_empty    = !ovld_r;
  assign piece_left   = pl_r;
  assign piece_top    = pt_r;
  assign piece_right  = pr_r;
  assign piece_bottom = pb_r;
  assign piece_valid  = pv_r;
  assign last_piece   = lp_r;

endmodule

`default_nettype wire

/* hdl/rectangle_difference_top.sv */
// rectangle difference A minus B: front classifier, item queue, piece emitter
// datapath: queue entry, then working item register, then output register
// throughput: one result beat per cycle from the single output register while
//   items are queued and out_pop takes each beat; n pieces (1 to 4) give n beats
// reset: rst_n synchronous active low empties the queue and output; payload kept
`default_nettype none

module rectangle_difference_top #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic signed [COORD_BITS-1:0]  in_a_left,
  input  wire logic signed [COORD_BITS-1:0]  in_a_top,
  input  wire logic signed [COORD_BITS-1:0]  in_a_right,
  input  wire logic signed [COORD_BITS-1:0]  in_a_bottom,
  input  wire logic signed [COORD_BITS-1:0]  in_b_left,
  input  wire logic signed [COORD_BITS-1:0]  in_b_top,
  input  wire logic signed [COORD_BITS-1:0]  in_b_right,
  input  wire logic signed [COORD_BITS-1:0]  in_b_bottom,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic signed [COORD_BITS-1:0]       out_piece_left,
  output logic signed [COORD_BITS-1:0]       out_piece_top,
  output logic signed [COORD_BITS-1:0]       out_piece_right,
  output logic signed [COORD_BITS-1:0]       out_piece_bottom,
  output logic                               out_piece_valid,
  output logic                               out_last_piece
);

  localparam int CRD_W = rd_pkg::NUM_CRD * COORD_BITS;
  localparam int Q_W   = CRD_W + $bits(rd_pkg::rd_ctl_t);

  rd_pkg::rd_ctl_t    f_ctl, q_ctl;
  logic [CRD_W-1:0]   f_crd, q_crd;
  logic [Q_W-1:0]     q_rdata;
  logic               q_empty, q_pop;
  logic [COORD_BITS-1:0] pl, pt, pr, pb;

  rd_front #(.COORD_BITS(COORD_BITS)) u_front (
    .a_left   (in_a_left),
    .a_top    (in_a_top),
    .a_right  (in_a_right),
    .a_bottom (in_a_bottom),
    .b_left   (in_b_left),
    .b_top    (in_b_top),
    .b_right  (in_b_right),
    .b_bottom (in_b_bottom),
    .ctl      (f_ctl),
    .crd      (f_crd)
  );

  rd_queue #(.WIDTH(Q_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata ({f_ctl, f_crd}),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_ctl = q_rdata[Q_W-1:CRD_W];
  assign q_crd = q_rdata[CRD_W-1:0];

  rd_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_ctl        (q_ctl),
    .q_crd        (q_crd),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .piece_left   (pl),
    .piece_top    (pt),
    .piece_right  (pr),
    .piece_bottom (pb),
    .piece_valid  (out_piece_valid),
    .last_piece   (out_last_piece)
  );

  assign out_piece_left   = pl;
  assign out_piece_top    = pt;
  assign out_piece_right  = pr;
  assign out_piece_bottom = pb;

endmodule

`default_nettype wire

/* hdl/rd_checker.sv */
// port-level checks for the rectangle difference block, bound to the top level
// depends on rectangle_difference_top_defines.svh
`default_nettype none
`include "rectangle_difference_top_defines.svh"

module rd_checker #(
  parameter int COORD_BITS = 16
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_full,
  input wire logic                          out_empty,
  input wire logic                          out_pop,
  input wire logic signed [COORD_BITS-1:0]  out_piece_left,
  input wire logic signed [COORD_BITS-1:0]  out_piece_top,
  input wire logic signed [COORD_BITS-1:0]  out_piece_right,
  input wire logic signed [COORD_BITS-1:0]  out_piece_bottom,
  input wire logic                          out_piece_valid,
  input wire logic                          out_last_piece
);

  // a waiting beat stays put until taken
  `RD_CHECK(a_out_hold, !out_empty && !out_pop |=> !out_empty && $stable(out_piece_left) && $stable(out_piece_right) && $stable(out_piece_top) && $stable(out_piece_bottom) && $stable(out_last_piece))

  // full cover beat is a lone zero item
  `RD_CHECK(a_cover_lone, !out_empty && !out_piece_valid |-> out_last_piece && out_piece_left == '0 && out_piece_top == '0 && out_piece_right == '0 && out_piece_bottom == '0)

  // pieces before the last of an item are real, non-empty rectangles
  `RD_CHECK(a_mid_piece_area, !out_empty && !out_last_piece |-> out_piece_valid && out_piece_left < out_piece_right && out_piece_top < out_piece_bottom)

  // reset leaves the output empty and the input not full
  `RD_CHECK_RST(a_reset_empty, !rst_n |=> out_empty && !in_full)

endmodule

bind rectangle_difference_top rd_checker #(.COORD_BITS(COORD_BITS)) u_rd_checker (.*);

`default_nettype wire
